// ===== rtl/rolling_kmer_encoder_defines.svh =====
// Assertion macros shared by the rolling k-mer encoder RTL.
`ifndef ROLLING_KMER_ENCODER_DEFINES_SVH
`define ROLLING_KMER_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RKE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rolling_kmer_encoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RKE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rolling_kmer_encoder: next-cycle check failed");

`endif

// ===== rtl/rke_pkg.sv =====
// Types and constants of the rolling k-mer encoder.
package rke_pkg;

    localparam int CODE_W  = 60;
    localparam int POS_W   = 16;
    localparam int SYM_W   = 5;
    localparam int CLASS_W = 2;
    localparam int RADIX_W = 6;
    localparam int KLEN_W  = 4;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;

    localparam int MAX_KMER     = 12;
    localparam int MAX_ALPHABET = 32;
    localparam int MAX_SEQUENCE = 65536;

    localparam logic [RADIX_W-1:0] RESET_ALPHABET = 6'd20;
    localparam logic [KLEN_W-1:0]  RESET_KMER     = 4'd6;
    localparam logic [POS_W-1:0]   RESET_START    = 16'd1;
    localparam logic [CODE_W-1:0]  RESET_WEIGHT   = CODE_W'(20 ** (6 - 1));

    // symbol classes; the fourth code counts as rejected
    localparam logic [CLASS_W-1:0] CLS_VALID  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_WILD   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_REJECT = 2'd2;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_ALPHABET = 2'd0;
    localparam logic [INDEX_W-1:0] REG_KMER     = 2'd1;
    localparam logic [INDEX_W-1:0] REG_START    = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol_code;
        logic [CLASS_W-1:0] symbol_class;
        logic               last_in_sequence;
    } sym_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] kmer_value;
        logic [POS_W-1:0]  kmer_start;
        logic              bad_symbol;
    } kmer_item_t;

    // effective (clamped) configuration
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [KLEN_W-1:0]  klen;
        logic [POS_W-1:0]   first;
    } cfg_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/rke_divider.sv =====
// Bit-serial restoring divider: 60-bit code by a radix of up to 32.
module rke_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rke_pkg::CODE_W-1:0] dividend,
    input  logic [rke_pkg::RADIX_W-1:0] divisor,
    output rke_pkg::div_stat_t         stat,
    output logic [rke_pkg::CODE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(rke_pkg::CODE_W);

    logic [rke_pkg::CODE_W-1:0]    q_reg;
    logic [rke_pkg::RADIX_W-2:0]   rem_reg;
    logic [rke_pkg::RADIX_W-1:0]   divisor_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [rke_pkg::RADIX_W-1:0]   rem_sh;
    logic [rke_pkg::RADIX_W-1:0]   rem_sub;
    logic                          ge;

    // remainder stays below the divisor, so five bits hold it
    assign rem_sh  = {rem_reg, q_reg[rke_pkg::CODE_W-1]};
    assign ge      = rem_sh >= divisor_reg;
    assign rem_sub = rem_sh - divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(rke_pkg::CODE_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg       <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[rke_pkg::CODE_W-2:0], ge};
            rem_reg <= ge ? rem_sub[rke_pkg::RADIX_W-2:0] : rem_sh[rke_pkg::RADIX_W-2:0];
        end
    end

    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// ===== rtl/rke_core.sv =====
// Window sequencer: shared multiplier, divider control and output register.
module rke_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rke_pkg::cfg_t          cfg,
    input  logic                   cfg_update,
    input  logic                   sym_valid,
    output logic                   sym_stall,
    input  rke_pkg::sym_item_t     sym_item,
    output logic                   kmer_valid,
    input  logic                   kmer_stall,
    output rke_pkg::kmer_item_t    kmer_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WEIGHT,
        S_DIV,
        S_OUT
    } state_t;

    state_t                          state_reg, state_next;
    logic [rke_pkg::CODE_W-1:0]      window_reg, window_next;
    logic [rke_pkg::KLEN_W-1:0]      filled_reg, filled_next;
    logic [rke_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [rke_pkg::CODE_W-1:0]      weight_reg, weight_next;
    logic [rke_pkg::KLEN_W-1:0]      wcnt_reg, wcnt_next;
    logic [rke_pkg::POS_W-1:0]       item_pos_reg, item_pos_next;
    logic                            last_reg, last_next;
    logic [rke_pkg::CODE_W-1:0]      prod_reg, prod_next;
    rke_pkg::kmer_item_t             pend_reg, pend_next;
    rke_pkg::kmer_item_t             out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic [rke_pkg::RADIX_W-1:0]     mul_b;
    logic [rke_pkg::CODE_W-1:0]      mul_p;
    logic                            accept;
    logic                            out_free;
    logic                            div_start;
    rke_pkg::div_stat_t              div_stat;
    logic [rke_pkg::CODE_W-1:0]      quotient;
    logic [rke_pkg::CODE_W-1:0]      step_code;
    logic [rke_pkg::KLEN_W-1:0]      step_filled;
    logic                            res_load;
    rke_pkg::kmer_item_t             res;

    rke_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (window_reg),
        .divisor  (cfg.radix),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // one multiplier: radix powers while building the weight, symbol * weight per step
    assign mul_b = (state_reg == S_WEIGHT) ? cfg.radix : {1'b0, sym_item.symbol_code};
    assign mul_p = rke_pkg::CODE_W'(weight_reg * mul_b);

    assign sym_stall = (state_reg != S_IDLE);
    assign accept    = sym_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !kmer_stall;

    assign step_code   = quotient + prod_reg;
    assign step_filled = (filled_reg < cfg.klen) ? filled_reg + 1'b1 : filled_reg;

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        filled_next    = filled_reg;
        pos_next       = pos_reg;
        weight_next    = weight_reg;
        wcnt_next      = wcnt_reg;
        item_pos_next  = item_pos_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        res_load       = 1'b0;
        res            = '0;

        if (out_valid_reg && !kmer_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next      = sym_item.last_in_sequence ? '0 : pos_reg + 1'b1;
                    item_pos_next = pos_reg;
                    last_next     = sym_item.last_in_sequence;
                    if (pos_reg >= cfg.first)
                    begin
                        if (sym_item.symbol_class == rke_pkg::CLS_WILD)
                        begin
                            window_next = '0;
                            filled_next = '0;
                        end
                        else if (sym_item.symbol_class != rke_pkg::CLS_VALID ||
                                 {1'b0, sym_item.symbol_code} >= cfg.radix)
                        begin
                            window_next    = '0;
                            filled_next    = '0;
                            res.kmer_value = '0;
                            res.kmer_start = pos_reg;
                            res.bad_symbol = 1'b1;
                            res_load       = 1'b1;
                        end
                        else
                        begin
                            prod_next  = mul_p;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    if (sym_item.last_in_sequence && !div_start)
                    begin
                        window_next = '0;
                        filled_next = '0;
                    end
                end
            end
            S_WEIGHT:
            begin
                if (wcnt_reg + 1'b1 >= cfg.klen)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    weight_next = mul_p;
                    wcnt_next   = wcnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_IDLE;
                    if (last_reg)
                    begin
                        window_next = '0;
                        filled_next = '0;
                    end
                    else
                    begin
                        window_next = step_code;
                        filled_next = step_filled;
                    end
                    if (step_filled >= cfg.klen)
                    begin
                        res.kmer_value = step_code;
                        res.kmer_start = item_pos_reg - rke_pkg::POS_W'(cfg.klen) + 1'b1;
                        res.bad_symbol = 1'b0;
                        res_load       = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            if (out_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next  = res;
                state_next = S_OUT;
            end
        end

        // register write: clear the window and rebuild N^(k-1)
        if (cfg_update)
        begin
            window_next = '0;
            filled_next = '0;
            weight_next = rke_pkg::CODE_W'(1);
            wcnt_next   = '0;
            state_next  = S_WEIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= '0;
            filled_reg    <= '0;
            pos_reg       <= '0;
            weight_reg    <= rke_pkg::RESET_WEIGHT;
            wcnt_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            filled_reg    <= filled_next;
            pos_reg       <= pos_next;
            weight_reg    <= weight_next;
            wcnt_reg      <= wcnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_pos_reg <= item_pos_next;
        prod_reg     <= prod_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign kmer_valid = out_valid_reg;
    assign kmer_item  = out_reg;

endmodule

// ===== rtl/rolling_kmer_encoder.sv =====
// Rolling base-N k-mer encoder: configuration registers and core.
//
// Symbols enter on sym_valid/sym_stall, one transaction per symbol; results
// leave on kmer_valid/kmer_stall, at most one per symbol. A valid symbol in
// range (past the start position) runs a 60-step serial division of the
// window code by the radix; the input stalls until the division is done
// and its result is registered. Wildcards and symbols before the start
// position leave the input ready; a rejected symbol does too unless its
// error result must wait in the pending slot.
// A register write (cfg_write, cfg_index, cfg_data) clears the window and
// rebuilds N^(k-1) with the shared multiplier while the input is stalled.
// Writes to an unused index are ignored.
// Results sit in an output register; while the receiver stalls, the block
// still takes one further symbol and holds its result in a pending slot.
// Reset (rst_n, asynchronous) restores radix 20, length 6, start 1, an
// empty window and position zero.
`include "rolling_kmer_encoder_defines.svh"

module rolling_kmer_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rke_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [rke_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          sym_valid,
    output logic                          sym_stall,
    input  rke_pkg::sym_item_t            sym_item,
    output logic                          kmer_valid,
    input  logic                          kmer_stall,
    output rke_pkg::kmer_item_t           kmer_item
);

    logic [rke_pkg::RADIX_W-1:0] alphabet_reg;
    logic [rke_pkg::KLEN_W-1:0]  kmer_len_reg;
    logic [rke_pkg::POS_W-1:0]   start_reg;
    logic                        cfg_hit;
    rke_pkg::cfg_t               cfg;

    assign cfg_hit = cfg_write && (cfg_index == rke_pkg::REG_ALPHABET ||
                                   cfg_index == rke_pkg::REG_KMER ||
                                   cfg_index == rke_pkg::REG_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_reg <= rke_pkg::RESET_ALPHABET;
            kmer_len_reg <= rke_pkg::RESET_KMER;
            start_reg    <= rke_pkg::RESET_START;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rke_pkg::REG_ALPHABET: alphabet_reg <= cfg_data[rke_pkg::RADIX_W-1:0];
                rke_pkg::REG_KMER:     kmer_len_reg <= cfg_data[rke_pkg::KLEN_W-1:0];
                rke_pkg::REG_START:    start_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // clamp to the supported ranges
    always_comb
    begin
        if (alphabet_reg < rke_pkg::RADIX_W'(2))
            cfg.radix = rke_pkg::RADIX_W'(2);
        else if (alphabet_reg > rke_pkg::RADIX_W'(rke_pkg::MAX_ALPHABET))
            cfg.radix = rke_pkg::RADIX_W'(rke_pkg::MAX_ALPHABET);
        else
            cfg.radix = alphabet_reg;

        if (kmer_len_reg == '0)
            cfg.klen = rke_pkg::KLEN_W'(1);
        else if (kmer_len_reg > rke_pkg::KLEN_W'(rke_pkg::MAX_KMER))
            cfg.klen = rke_pkg::KLEN_W'(rke_pkg::MAX_KMER);
        else
            cfg.klen = kmer_len_reg;

        cfg.first = (start_reg == '0) ? '0 : start_reg - 1'b1;
    end

    rke_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_update (cfg_hit),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_item   (sym_item),
        .kmer_valid (kmer_valid),
        .kmer_stall (kmer_stall),
        .kmer_item  (kmer_item)
    );

    // a write to a used register always triggers the weight rebuild
    `RKE_ASSERT_NEXT(a_cfg_stalls, cfg_hit, sym_stall)
    // a wildcard does not stall the symbol after it
    `RKE_ASSERT_NEXT(a_wild_quick,
        sym_valid && !sym_stall && !cfg_write &&
        sym_item.symbol_class == rke_pkg::CLS_WILD, !sym_stall)
    // an error result carries an empty code
    `RKE_ASSERT_SAME(a_bad_zero, kmer_valid && kmer_item.bad_symbol,
        kmer_item.kmer_value == '0)

endmodule

// ===== tb/sv/rolling_kmer_encoder_test.sv =====
// Self-checking testbench for the rolling k-mer encoder: directed table, then random phases.
module rolling_kmer_encoder_test;
    import rke_pkg::*;

    localparam logic [CLASS_W-1:0] CLS_SPARE   = 2'd3;   // unused class, taken as rejected
    localparam logic [INDEX_W-1:0] REG_NONE    = 2'd3;   // no register behind this index
    localparam int                 CYCLE_LIMIT = 1_500_000;
    localparam int                 DRAIN_WAIT  = 80;     // serial divide of one symbol, with margin
    localparam int                 LONG_HOLD   = 400;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic [INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic       sym_valid;
    logic       sym_stall;
    sym_item_t  sym_item;
    logic       kmer_valid;
    logic       kmer_stall;
    kmer_item_t kmer_item;

    rolling_kmer_encoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sym_valid  (sym_valid),
        .sym_stall  (sym_stall),
        .sym_item   (sym_item),
        .kmer_valid (kmer_valid),
        .kmer_stall (kmer_stall),
        .kmer_item  (kmer_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // encoder state as the testbench sees it
    logic [RADIX_W-1:0] reg_alphabet;
    logic [KLEN_W-1:0]  reg_kmer;
    logic [POS_W-1:0]   reg_start;
    logic [CODE_W-1:0]  win_code;
    logic [CODE_W-1:0]  top_weight;
    logic [KLEN_W-1:0]  win_fill;
    logic [POS_W-1:0]   next_pos;

    kmer_item_t expected_kmers[$];

    int  mismatches     = 0;
    int  taken_count    = 0;
    int  settings_count = 0;
    int  codes_seen     = 0;
    int  flags_seen     = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    int  hold_requests  = 0;

    typedef struct {
        bit                 is_write;
        logic [INDEX_W-1:0] reg_index;
        logic [CFG_W-1:0]   reg_data;
        sym_item_t          symbol;
        bit                 typed;
        kmer_item_t         typed_result;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic int eff_radix();
        if (reg_alphabet < 2)
            return 2;
        if (reg_alphabet > MAX_ALPHABET)
            return MAX_ALPHABET;
        return int'(reg_alphabet);
    endfunction

    function automatic int eff_len();
        if (reg_kmer < 1)
            return 1;
        if (reg_kmer > MAX_KMER)
            return MAX_KMER;
        return int'(reg_kmer);
    endfunction

    function automatic void apply_register(input logic [INDEX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        longint unsigned w;
        int i;
        case (idx)
            REG_ALPHABET: reg_alphabet = data[RADIX_W-1:0];
            REG_KMER:     reg_kmer     = data[KLEN_W-1:0];
            REG_START:    reg_start    = data;
            default:      return;
        endcase
        w = 1;
        for (i = 1; i < eff_len(); i++)
            w = w * 64'(eff_radix());
        top_weight = w[CODE_W-1:0];
        win_code   = '0;
        win_fill   = '0;
    endfunction

    function automatic void predict_symbol(input sym_item_t it, output bit taken,
                                           output bit has_res, output kmer_item_t res);
        int n;
        int k;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] pos;
        longint unsigned acc;
        n       = eff_radix();
        k       = eff_len();
        first   = (reg_start == '0) ? '0 : reg_start - 16'd1;
        pos     = next_pos;
        next_pos = pos + 16'd1;
        taken   = (pos >= first);
        has_res = 1'b0;
        res     = '0;
        if (taken)
        begin
            if (it.symbol_class == CLS_WILD)
            begin
                win_code = '0;
                win_fill = '0;
            end
            else if (it.symbol_class != CLS_VALID || int'(it.symbol_code) >= n)
            begin
                win_code       = '0;
                win_fill       = '0;
                res.kmer_start = pos;
                res.bad_symbol = 1'b1;
                has_res        = 1'b1;
            end
            else
            begin
                acc = 64'(win_code) / 64'(n) + 64'(it.symbol_code) * 64'(top_weight);
                win_code = acc[CODE_W-1:0];
                if (int'(win_fill) < k)
                    win_fill++;
                if (int'(win_fill) >= k)
                begin
                    res.kmer_value = win_code;
                    res.kmer_start = pos - 16'(k - 1);
                    has_res        = 1'b1;
                end
            end
        end
        if (it.last_in_sequence)
        begin
            win_code = '0;
            win_fill = '0;
            next_pos = '0;
        end
    endfunction

    function automatic stim_row_t sym_row(input logic [SYM_W-1:0] code,
                                          input logic [CLASS_W-1:0] cls, input logic last);
        stim_row_t r;
        r = '{default: '0};
        r.symbol = '{symbol_code: code, symbol_class: cls, last_in_sequence: last};
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [SYM_W-1:0] code,
                                            input logic [CLASS_W-1:0] cls, input logic last,
                                            input logic [CODE_W-1:0] kcode,
                                            input logic [POS_W-1:0] kstart, input logic bad);
        stim_row_t r;
        r = sym_row(code, cls, last);
        r.typed        = 1'b1;
        r.typed_result = '{kmer_value: kcode, kmer_start: kstart, bad_symbol: bad};
        return r;
    endfunction

    function automatic stim_row_t write_row(input logic [INDEX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        stim_row_t r;
        r = '{default: '0};
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    function automatic sym_item_t noise_symbol(input int n);
        sym_item_t it;
        int r;
        r = $urandom_range(0, 99);
        it.symbol_code      = 5'($urandom_range(0, 31));
        it.last_in_sequence = ($urandom_range(0, 5) == 0);
        if (r < 35)
        begin
            it.symbol_code  = 5'($urandom_range(0, n - 1));
            it.symbol_class = CLS_VALID;
        end
        else if (r < 55)
            it.symbol_class = CLS_WILD;
        else if (r < 70)
            it.symbol_class = CLS_REJECT;
        else if (r < 85 && n < MAX_ALPHABET)
        begin
            it.symbol_code  = 5'($urandom_range(n, 31));
            it.symbol_class = CLS_VALID;
        end
        else
            it.symbol_class = CLS_SPARE;
        return it;
    endfunction

    task automatic offer_symbol(input sym_item_t it, input bit typed, input kmer_item_t want);
        int gap;
        bit taken;
        bit has_res;
        kmer_item_t res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                sym_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        sym_valid <= 1'b1;
        sym_item  <= it;
        do @(posedge clk); while (sym_stall);
        predict_symbol(it, taken, has_res, res);
        if (taken)
            taken_count++;
        if (typed)
            expected_kmers.push_back(want);
        else if (has_res)
            expected_kmers.push_back(res);
    endtask

    task automatic idle_sender();
        @(negedge clk);
        sym_valid <= 1'b0;
        burst_left = 0;
    endtask

    // a symbol that gives no result may still sit in the divider once the queue is empty
    task automatic settle();
        idle_sender();
        while (expected_kmers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic reconfigure(input int a, input int kl, input int st);
        settle();
        write_register(REG_ALPHABET, {10'($urandom), 6'(a)});
        write_register(REG_KMER, {12'($urandom), 4'(kl)});
        write_register(REG_START, 16'(st));
        settings_count++;
    endtask

    // mostly clean runs of valid symbols long enough to fill the window, some noise
    task automatic run_phase(input int quota, input bit pause_mid);
        int n;
        int k;
        int len;
        int kind;
        int j;
        int first_count;
        bit paused;
        sym_item_t it;
        n = eff_radix();
        k = eff_len();
        first_count = taken_count;
        paused = 1'b0;
        while (taken_count - first_count < quota)
        begin
            kind = $urandom_range(0, 99);
            len  = (kind < 80) ? $urandom_range(k, 3 * k + 4) : $urandom_range(1, 8);
            for (j = 0; j < len; j++)
            begin
                if (kind < 70)
                    it = '{symbol_code: 5'($urandom_range(0, n - 1)),
                           symbol_class: CLS_VALID, last_in_sequence: 1'b0};
                else if (kind < 80)
                    it = '{symbol_code: (kind < 75) ? 5'(n - 1) : 5'd0,
                           symbol_class: CLS_VALID, last_in_sequence: 1'b0};
                else
                    it = noise_symbol(n);
                if (kind < 80 && j == len - 1)
                    it.last_in_sequence = 1'($urandom_range(0, 1));
                offer_symbol(it, 1'b0, '0);
            end
            if (pause_mid && !paused && taken_count - first_count >= quota / 2)
            begin
                idle_sender();
                while (expected_kmers.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
        end
    endtask

    always @(posedge clk)
    begin : check_results
        kmer_item_t want;
        if (rst_n && kmer_valid && !kmer_stall)
        begin
            if (expected_kmers.size() == 0)
            begin
                $error("unexpected k-mer transaction: code %0h start %0d bad %0b",
                       kmer_item.kmer_value, kmer_item.kmer_start, kmer_item.bad_symbol);
                mismatches++;
            end
            else
            begin
                want = expected_kmers.pop_front();
                if (want.bad_symbol)
                    flags_seen++;
                else
                    codes_seen++;
                if (kmer_item.kmer_value !== want.kmer_value)
                begin
                    $error("kmer_value: expected %0h, got %0h",
                           want.kmer_value, kmer_item.kmer_value);
                    mismatches++;
                end
                if (kmer_item.kmer_start !== want.kmer_start)
                begin
                    $error("kmer_start: expected %0d, got %0d",
                           want.kmer_start, kmer_item.kmer_start);
                    mismatches++;
                end
                if (kmer_item.bad_symbol !== want.bad_symbol)
                begin
                    $error("bad_symbol: expected %0b, got %0b",
                           want.bad_symbol, kmer_item.bad_symbol);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rolling_kmer_encoder_test: errors");
            $finish;
        end
    end

    // receiver: random stall modes, plus one long hold on request
    initial
    begin : receiver
        int mode_left;
        int stall_pct;
        int hold_left;
        int hold_served;
        kmer_stall  = 1'b0;
        mode_left   = 0;
        stall_pct   = 0;
        hold_left   = 0;
        hold_served = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                kmer_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                kmer_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin : stimulus
        int p;
        int a;
        int kl;
        int st;
        int i;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_ALPHABET;
        cfg_data  = '0;
        sym_valid = 1'b0;
        sym_item  = '0;

        reg_alphabet = RESET_ALPHABET;
        reg_kmer     = RESET_KMER;
        reg_start    = RESET_START;
        top_weight   = RESET_WEIGHT;
        win_code     = '0;
        win_fill     = '0;
        next_pos     = '0;

        // reset settings: radix 20, length 6, start 1
        directed_rows.push_back(known_row(5'd0, CLS_REJECT, 1'b0, 60'd0, 16'd0, 1'b1));
        directed_rows.push_back(known_row(5'd31, CLS_SPARE, 1'b0, 60'd0, 16'd1, 1'b1));
        directed_rows.push_back(known_row(5'd20, CLS_VALID, 1'b0, 60'd0, 16'd2, 1'b1));
        directed_rows.push_back(sym_row(5'd0, CLS_WILD, 1'b0));
        for (i = 0; i < 5; i++)
            directed_rows.push_back(sym_row(5'd19, CLS_VALID, 1'b0));
        // six top digits: 20^6 - 1
        directed_rows.push_back(known_row(5'd19, CLS_VALID, 1'b0, 60'd63999999, 16'd4, 1'b0));
        directed_rows.push_back(sym_row(5'd0, CLS_VALID, 1'b1));
        // zero in every register clamps to radix 2, length 1, start 1
        directed_rows.push_back(write_row(REG_START, 16'd0));
        directed_rows.push_back(write_row(REG_KMER, 16'd0));
        directed_rows.push_back(write_row(REG_ALPHABET, 16'd0));
        directed_rows.push_back(known_row(5'd1, CLS_VALID, 1'b0, 60'd1, 16'd0, 1'b0));
        directed_rows.push_back(known_row(5'd2, CLS_VALID, 1'b0, 60'd0, 16'd1, 1'b1));
        // position is kept over the write, so two symbols fall before the start
        directed_rows.push_back(write_row(REG_START, 16'd5));
        directed_rows.push_back(sym_row(5'd1, CLS_VALID, 1'b0));
        directed_rows.push_back(sym_row(5'd1, CLS_VALID, 1'b0));
        directed_rows.push_back(sym_row(5'd1, CLS_VALID, 1'b1));
        directed_rows.push_back(write_row(REG_ALPHABET, 16'hFFFF));
        directed_rows.push_back(write_row(REG_KMER, 16'hFFFF));
        directed_rows.push_back(write_row(REG_NONE, 16'hFFFF));
        directed_rows.push_back(write_row(REG_START, 16'd1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                settle();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else
                offer_symbol(directed_rows[i].symbol, directed_rows[i].typed,
                             directed_rows[i].typed_result);
        end

        for (p = 0; p < 11; p++)
        begin
            case (p)
                0: begin a = 2;  kl = 1;  st = 1; end
                1: begin a = 32; kl = 12; st = 1; end
                2: begin a = 0;  kl = 0;  st = 0; end
                3: begin a = 63; kl = 15; st = 7; end
                4: begin a = 1;  kl = 13; st = 2; end
                5: begin a = 3;  kl = 12; st = 1; end
                default:
                begin
                    a  = $urandom_range(2, 32);
                    kl = $urandom_range(1, 12);
                    st = $urandom_range(1, 6);
                end
            endcase
            reconfigure(a, kl, st);
            // short windows: the block fills while the receiver holds off
            if (p == 0)
                hold_requests++;
            run_phase(48, p == 1);
        end

        // start beyond any position reached: everything is dropped
        reconfigure(20, 6, 16'hFFFF);
        repeat (30) offer_symbol(noise_symbol(eff_radix()), 1'b0, '0);

        // long windows in a small radix, closed by a last symbol
        reconfigure(4, 12, 1);
        repeat (24)
            offer_symbol('{symbol_code: 5'($urandom_range(0, 3)), symbol_class: CLS_VALID,
                           last_in_sequence: 1'b0}, 1'b0, '0);
        offer_symbol('{symbol_code: 5'd3, symbol_class: CLS_VALID, last_in_sequence: 1'b1},
                     1'b0, '0);

        idle_sender();
        while (expected_kmers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_kmers.size() != 0)
        begin
            $error("%0d k-mer transactions never arrived", expected_kmers.size());
            mismatches++;
        end

        $display("rolling_kmer_encoder_test: %0d symbols taken under %0d register settings",
                 taken_count, settings_count);
        $display("rolling_kmer_encoder_test: %0d window codes and %0d bad-symbol flags compared",
                 codes_seen, flags_seen);
        if (mismatches == 0)
            $display("rolling_kmer_encoder_test: clean");
        else
            $display("rolling_kmer_encoder_test: errors");
        $finish;
    end

endmodule

// ===== rolling_kmer_encoder.f =====
+incdir+rtl
rtl/rke_pkg.sv
rtl/rke_divider.sv
rtl/rke_core.sv
rtl/rolling_kmer_encoder.sv
tb/sv/rolling_kmer_encoder_test.sv
